### hdl/keyword_substitution_cipher_assert.svh
// Assertion macros shared by the keyword substitution cipher RTL.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define KWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another condition in the next.
`define KWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/kwsc_pkg.sv
// Types, codes and character helpers shared by the keyword substitution cipher.
package kwsc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [4:0] idx_t;
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_CLEAR = 2'd0;
  localparam mode_t MODE_KEY   = 2'd1;
  localparam mode_t MODE_TEXT  = 2'd2;

  localparam idx_t ALPHA_N     = 5'd26;
  localparam idx_t LAST_LETTER = 5'd25;

  localparam char_t CHAR_UA  = 8'h41;
  localparam char_t CHAR_UZ  = 8'h5A;
  localparam char_t CHAR_LA  = 8'h61;
  localparam char_t CHAR_LZ  = 8'h7A;
  localparam char_t CASE_GAP = 8'h20;

  function automatic logic is_upper(input char_t c);
    return (c >= CHAR_UA) && (c <= CHAR_UZ);
  endfunction

  function automatic logic is_lower(input char_t c);
    return (c >= CHAR_LA) && (c <= CHAR_LZ);
  endfunction

  // Letter index of a byte; only meaningful when the byte is a letter.
  function automatic idx_t letter_idx(input char_t c);
    char_t diff;
    diff = is_upper(c) ? (c - CHAR_UA) : (c - CHAR_LA);
    return diff[4:0];
  endfunction

endpackage

### hdl/kwsc_in_if.sv
// Input channel of the cipher: command mode and byte, with valid/ready.
interface kwsc_in_if import kwsc_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  char_t in_char;

  modport source (output valid, output mode, output in_char, input ready);
  modport sink   (input valid, input mode, input in_char, output ready);
endinterface

### hdl/kwsc_out_if.sv
// Result channel of the cipher: substituted byte, with valid/ready.
interface kwsc_out_if import kwsc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;

  modport source (output valid, output out_char, input ready);
  modport sink   (input valid, input out_char, output ready);
endinterface

### hdl/kwsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kwsc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/keyword_substitution_cipher.sv
// Keyword substitution cipher: key collection, table build and byte lookup.
//
// Usage: beats on in_ch carry a mode and a byte. Mode 0 clears the key, mode 1
// appends a key letter (upper-cased; duplicates and non-letters are dropped),
// mode 2 substitutes a text byte and yields exactly one beat on out_ch. Mode 3
// is ignored. The cfg_we/cfg_wdata port sets the direction: 0 encrypts with
// the cipher alphabet, 1 decrypts with its inverse; write it only while idle.
// Key letters are stored straight into the leading positions of the cipher
// table, so the block keeps just two memories: the cipher table and its inverse.
// Sequencing: key and clear beats are handled in the idle state. A text beat on
// current tables is accepted with its table read; its result is then loaded in
// the response state once out_ch is free, and no new beat is taken before that.
// The first text beat after the key changes first rebuilds both tables: per key
// letter a read of the key letter from the cipher table, then a write of its
// inverse entry; then a sweep of the remaining letters from Z down; then a
// lookup step. The cipher table's single read port sets the per-letter cost.
// Reset empties the key and marks the tables stale; no clearing pass is run.
// A result sits in the out_ch register until taken; while it waits the block
// keeps accepting key beats and can look up the next text byte, holding that
// result back until the register frees.
module keyword_substitution_cipher import kwsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  kwsc_in_if.sink       in_ch,
  kwsc_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

`include "keyword_substitution_cipher_assert.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_KEY_RD = 3'd1;
  localparam logic [2:0] ST_KEY_WR = 3'd2;
  localparam logic [2:0] ST_REST   = 3'd3;
  localparam logic [2:0] ST_LOOK   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  idx_t        key_count_r, key_count_nxt;
  logic [25:0] letter_used_r, letter_used_nxt;
  logic        tables_ready_r, tables_ready_nxt;
  logic        dir_r;
  char_t       char_r, char_nxt;
  idx_t        pos_r, pos_nxt;
  idx_t        letter_r, letter_nxt;
  logic        out_valid_r, out_valid_nxt;
  char_t       out_char_r, out_char_nxt;

  logic        in_fire;
  char_t       key_up;
  idx_t        key_idx;
  logic        key_we;

  logic        key_re;
  logic        tab_we;
  idx_t        fill_letter;
  logic        enc_we, enc_re;
  idx_t        enc_waddr, enc_wdata, enc_raddr, dec_waddr, dec_wdata;
  char_t       lk_char;
  logic        lk_re;
  idx_t        enc_rdata, dec_rdata, tab_rdata;
  char_t       result;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;

  // Key byte, upper-cased, and its letter index.
  assign key_up  = is_lower(in_ch.in_char) ? (in_ch.in_char - CASE_GAP) : in_ch.in_char;
  assign key_idx = letter_idx(key_up);
  assign key_we  = in_fire && (in_ch.mode == MODE_KEY) && is_upper(key_up) &&
                   !letter_used_r[key_idx] && (key_count_r < ALPHA_N);

  // Table build: the key letters already sit in the first positions of the
  // cipher table; each is read back to fill its inverse entry. Then every
  // unused letter from Z downward goes into both tables.
  assign key_re      = (state_r == ST_KEY_RD);
  assign tab_we      = (state_r == ST_KEY_WR) ||
                       ((state_r == ST_REST) && !letter_used_r[letter_r]);
  assign fill_letter = (state_r == ST_KEY_WR) ? enc_rdata : letter_r;
  assign dec_waddr   = fill_letter;
  assign dec_wdata   = pos_r;

  // A new key letter is appended at the key count; build writes go to pos_r.
  assign enc_we    = key_we || tab_we;
  assign enc_waddr = key_we ? key_count_r : pos_r;
  assign enc_wdata = key_we ? key_idx : fill_letter;

  // Lookup is issued on accept when the tables are current, else after build.
  assign lk_char   = (state_r == ST_IDLE) ? in_ch.in_char : char_r;
  assign lk_re     = (is_upper(lk_char) || is_lower(lk_char)) &&
                     ((state_r == ST_LOOK) ||
                      (in_fire && (in_ch.mode == MODE_TEXT) && tables_ready_r));
  assign enc_re    = key_re || (lk_re && !dir_r);
  assign enc_raddr = key_re ? pos_r : letter_idx(lk_char);

  kwsc_ram #(.WIDTH(5), .DEPTH(26)) u_enc_mem (
    .clk   (clk),
    .we    (enc_we),
    .waddr (enc_waddr),
    .wdata (enc_wdata),
    .re    (enc_re),
    .raddr (enc_raddr),
    .rdata (enc_rdata)
  );

  kwsc_ram #(.WIDTH(5), .DEPTH(26)) u_dec_mem (
    .clk   (clk),
    .we    (tab_we),
    .waddr (dec_waddr),
    .wdata (dec_wdata),
    .re    (lk_re && dir_r),
    .raddr (letter_idx(lk_char)),
    .rdata (dec_rdata)
  );

  // Case is kept: the table entry is added back onto the byte's own base.
  assign tab_rdata = dir_r ? dec_rdata : enc_rdata;
  always_comb begin
    if (is_upper(char_r)) begin
      result = CHAR_UA + {3'b000, tab_rdata};
    end else if (is_lower(char_r)) begin
      result = CHAR_LA + {3'b000, tab_rdata};
    end else begin
      result = char_r;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    key_count_nxt    = key_count_r;
    letter_used_nxt  = letter_used_r;
    tables_ready_nxt = tables_ready_r;
    char_nxt         = char_r;
    pos_nxt          = pos_r;
    letter_nxt       = letter_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_char_nxt     = out_char_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.mode)
            MODE_CLEAR: begin
              key_count_nxt    = '0;
              letter_used_nxt  = '0;
              tables_ready_nxt = 1'b0;
            end
            MODE_KEY: begin
              if (key_we) begin
                key_count_nxt            = key_count_r + 5'd1;
                letter_used_nxt[key_idx] = 1'b1;
                tables_ready_nxt         = 1'b0;
              end
            end
            MODE_TEXT: begin
              char_nxt   = in_ch.in_char;
              pos_nxt    = '0;
              letter_nxt = LAST_LETTER;
              if (tables_ready_r) begin
                state_nxt = ST_RESP;
              end else if (key_count_r != '0) begin
                state_nxt = ST_KEY_RD;
              end else begin
                state_nxt = ST_REST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_KEY_RD: begin
        state_nxt = ST_KEY_WR;
      end
      ST_KEY_WR: begin
        pos_nxt   = pos_r + 5'd1;
        state_nxt = ((pos_r + 5'd1) == key_count_r) ? ST_REST : ST_KEY_RD;
      end
      ST_REST: begin
        if (!letter_used_r[letter_r]) begin
          pos_nxt = pos_r + 5'd1;
        end
        if (letter_r == '0) begin
          tables_ready_nxt = 1'b1;
          state_nxt        = ST_LOOK;
        end else begin
          letter_nxt = letter_r - 5'd1;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = result;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      key_count_r    <= '0;
      letter_used_r  <= '0;
      tables_ready_r <= 1'b0;
      dir_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      key_count_r    <= key_count_nxt;
      letter_used_r  <= letter_used_nxt;
      tables_ready_r <= tables_ready_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    pos_r      <= pos_nxt;
    letter_r   <= letter_nxt;
    out_char_r <= out_char_nxt;
  end

  // The sweep must end with all 26 table positions filled.
  `KWSC_ASSERT(a_build_full, ((state_r == ST_REST) && (letter_r == '0)) |-> ((pos_r + {4'b0000, !letter_used_r[0]}) == ALPHA_N), "table build did not fill all positions")
  // A lookup after build always sees current tables.
  `KWSC_ASSERT(a_look_ready, (state_r == ST_LOOK) |-> tables_ready_r, "lookup with stale tables")
  // A new result beat only comes from the response step.
  `KWSC_ASSERT(a_out_src, $rose(out_valid_r) |-> ($past(state_r) == ST_RESP), "result beat without a lookup")
  // Key letters are never appended past a full key, and an append marks the tables stale.
  `KWSC_ASSERT_NEXT(a_key_cap, key_we, (key_count_r <= ALPHA_N) && tables_ready_r == 1'b0, "key append overflow or stale flag not cleared")

endmodule

### test/kwsc_cipher_checker.sv
// Checker for the keyword substitution cipher: tracks key and tables, predicts and compares.
module kwsc_cipher_checker import kwsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_ready,
  input  mode_t in_mode,
  input  char_t in_char,
  input  logic  out_valid,
  input  logic  out_ready,
  input  char_t out_char,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  output int    mismatch_count,
  output int    chars_outstanding
);

  idx_t        key_seq [26];
  idx_t        key_len;
  logic [25:0] key_used;
  idx_t        enc_map [26];
  idx_t        dec_map [26];
  logic        maps_fresh;
  logic        decrypt_dir;
  char_t       expected_chars [$];

  // Key letters first, then every letter not in the key from Z down to A.
  function automatic void rebuild_maps();
    int pos;
    pos = 0;
    for (int i = 0; i < int'(key_len); i++) begin
      enc_map[pos] = key_seq[i];
      pos++;
    end
    for (int letter = 25; letter >= 0 && pos < 26; letter--) begin
      if (!key_used[letter]) begin
        enc_map[pos] = idx_t'(letter);
        pos++;
      end
    end
    for (int i = 0; i < 26; i++) dec_map[enc_map[i]] = idx_t'(i);
    maps_fresh = 1'b1;
  endfunction

  function automatic idx_t map_letter(input idx_t li);
    return decrypt_dir ? dec_map[li] : enc_map[li];
  endfunction

  function automatic void absorb_beat(input mode_t m, input char_t c);
    char_t up;
    idx_t  li;
    char_t res;
    case (m)
      MODE_CLEAR: begin
        key_len    = '0;
        key_used   = '0;
        maps_fresh = 1'b0;
      end
      MODE_KEY: begin
        up = (c >= CHAR_LA && c <= CHAR_LZ) ? char_t'(c - CASE_GAP) : c;
        if (up >= CHAR_UA && up <= CHAR_UZ) begin
          li = idx_t'(up - CHAR_UA);
          if (!key_used[li] && key_len < ALPHA_N) begin
            key_seq[key_len] = li;
            key_len++;
            key_used[li] = 1'b1;
            maps_fresh   = 1'b0;
          end
        end
      end
      MODE_TEXT: begin
        if (!maps_fresh) rebuild_maps();
        res = c;
        if (c >= CHAR_UA && c <= CHAR_UZ) begin
          res = CHAR_UA + map_letter(idx_t'(c - CHAR_UA));
        end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
          res = CHAR_LA + map_letter(idx_t'(c - CHAR_LA));
        end
        expected_chars.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    char_t want;
    if (!rst_n) begin
      key_len        = '0;
      key_used       = '0;
      maps_fresh     = 1'b0;
      decrypt_dir    = 1'b0;
      mismatch_count = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we) decrypt_dir = cfg_wdata;
      if (in_valid && in_ready) absorb_beat(in_mode, in_char);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: expected none, actual %02h", out_char);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want) begin
            $error("out_char: expected %02h, actual %02h", want, out_char);
            mismatch_count++;
          end
        end
      end
    end
    chars_outstanding = expected_chars.size();
  end

endmodule

### test/tb_keyword_substitution_cipher.sv
// Testbench top for the keyword substitution cipher: stimulus, receiver, watchdog and verdict.
module tb_keyword_substitution_cipher;
  import kwsc_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  // Longest correct quiet stretch is the long receiver hold or a table rebuild plus a
  // long sender gap; the limit is several times either.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  // Settle well past a table rebuild before any direction write and at the end of the run.
  localparam int SETTLE_CYCLES  = 120;
  localparam int PHASES         = 10;
  localparam int PHASE_BEATS    = 150;
  localparam int HOLD_PHASE     = 4;

  // The block ignores this mode; the package has no name for it.
  localparam mode_t MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  kwsc_in_if  in_ch ();
  kwsc_out_if out_ch ();

  int mismatches;
  int chars_outstanding;
  int sent_beats;
  int idle_cycles;
  bit no_idle;
  bit hold_req;

  always #(CLK_HALF) clk = ~clk;

  keyword_substitution_cipher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  kwsc_cipher_checker u_cipher_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_mode          (in_ch.mode),
    .in_char          (in_ch.in_char),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_char         (out_ch.out_char),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatches),
    .chars_outstanding(chars_outstanding)
  );

  // Gap lengths for both sides: mostly none or short, now and then a long one.
  // During the steady phases neither side idles at all.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Text bytes lean toward letters of both cases, so the lookup is exercised,
  // with a share of arbitrary bytes, of which the non-letters must pass through untouched.
  function automatic char_t text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CHAR_UA + char_t'($urandom_range(0, 25));
    if (r < 75) return CHAR_LA + char_t'($urandom_range(0, 25));
    return char_t'($urandom);
  endfunction

  // Key bytes: mostly letters of either case, which also produces repeats, plus
  // arbitrary bytes, which the block has to drop unless they are letters.
  function automatic char_t key_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CHAR_UA + char_t'($urandom_range(0, 25));
    if (r < 80) return CHAR_LA + char_t'($urandom_range(0, 25));
    return char_t'($urandom);
  endfunction

  // Receiver: random ready with gaps from the same distribution as the sender.
  // When the stimulus asks for it, ready stays low for a long stretch counted
  // here, so the block fills up while the sender keeps offering beats.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel means the
  // block has hung or an expected result never came.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("keyword_substitution_cipher regression: fail");
        $finish;
      end
    end
  end

  // Offers one beat after a random gap and returns at the falling edge after
  // it was taken. Valid stays high on return, so a caller that sends again at
  // once keeps it high without a drop in between.
  task automatic send_beat(input mode_t m, input char_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.in_char <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (m != MODE_UNUSED) sent_beats++;
    @(negedge clk);
  endtask

  // Drops valid, waits until every text beat has its result, then lets the
  // block finish any rebuild or key beat still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (chars_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_direction(input logic v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Every letter once, in a shuffled order and random case, then one to three
  // more key bytes that must all be dropped because the key is already full.
  task automatic send_full_key();
    idx_t  order [26];
    idx_t  swap;
    int    j;
    char_t base;
    for (int i = 0; i < 26; i++) order[i] = idx_t'(i);
    for (int i = 25; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < 26; i++) begin
      base = $urandom_range(0, 1) ? CHAR_LA : CHAR_UA;
      send_beat(MODE_KEY, base + order[i]);
    end
    repeat ($urandom_range(1, 3)) send_beat(MODE_KEY, key_byte());
  endtask

  // One random session. Most are well formed: an optional clear, a key of
  // random length (sometimes the whole alphabet), then a run of text. The rest
  // is noise in any mode, the ignored one included, which also breaks keys
  // apart and leaves text beats arriving against stale tables.
  task automatic run_session();
    mode_t all_modes [4];
    all_modes = '{MODE_CLEAR, MODE_KEY, MODE_TEXT, MODE_UNUSED};
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        send_beat(all_modes[$urandom_range(0, 3)], char_t'($urandom));
      end
    end else begin
      if ($urandom_range(0, 3) != 0) send_beat(MODE_CLEAR, char_t'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        send_full_key();
      end else begin
        repeat ($urandom_range(0, 8)) send_beat(MODE_KEY, key_byte());
      end
      repeat ($urandom_range(1, 16)) send_beat(MODE_TEXT, text_byte());
    end
  endtask

  initial begin
    int phase_start;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_CLEAR;
    in_ch.in_char = '0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    sent_beats    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, encrypting. With an empty key the alphabet is Z down to A.
    write_direction(1'b0);
    send_beat(MODE_TEXT, CHAR_UA);
    send_beat(MODE_TEXT, CHAR_LZ);
    // Bytes just outside the letter ranges, zero, and high bytes pass through.
    send_beat(MODE_TEXT, 8'h00);
    send_beat(MODE_TEXT, 8'hFF);
    send_beat(MODE_TEXT, 8'h80);
    send_beat(MODE_TEXT, CHAR_UA - 8'd1);
    send_beat(MODE_TEXT, CHAR_UZ + 8'd1);
    send_beat(MODE_TEXT, CHAR_LA - 8'd1);
    send_beat(MODE_TEXT, CHAR_LZ + 8'd1);
    // The unused mode is ignored even when it carries a letter.
    send_beat(MODE_UNUSED, CHAR_UA);
    // Key: a lower-case letter, an upper-case one, another lower-case one, then a repeat
    // that differs only in case, a digit and a high byte, which are all dropped.
    send_beat(MODE_KEY, CHAR_LA + 8'd10);
    send_beat(MODE_KEY, CHAR_UA + 8'd4);
    send_beat(MODE_KEY, CHAR_LA + 8'd24);
    send_beat(MODE_KEY, CHAR_UA + 8'd10);
    send_beat(MODE_KEY, 8'h31);
    send_beat(MODE_KEY, 8'hC1);
    // First text after the key change forces the rebuild.
    send_beat(MODE_TEXT, CHAR_UA);
    send_beat(MODE_TEXT, CHAR_LA + 8'd12);
    send_beat(MODE_TEXT, CHAR_UZ);
    drain();

    // Switch to decrypting against tables that are already built.
    write_direction(1'b1);
    send_beat(MODE_TEXT, CHAR_UA + 8'd10);
    send_beat(MODE_TEXT, CHAR_LA + 8'd2);
    send_beat(MODE_TEXT, CHAR_UA + 8'd16);
    // Clearing the key brings back the reversed alphabet.
    send_beat(MODE_CLEAR, 8'hA5);
    send_beat(MODE_TEXT, CHAR_UA + 8'd1);
    drain();

    // Random part. Each phase starts idle with a fresh direction; the first
    // phases alternate so both settings are covered early. Two phases run
    // with no idling on either side, and one carries the long receiver hold.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) write_direction(p[0]);
      else write_direction(1'($urandom_range(0, 1)));
      no_idle  = (p == 2 || p == 6);
      hold_req = (p == HOLD_PHASE);
      phase_start = sent_beats;
      while (sent_beats - phase_start < PHASE_BEATS) run_session();
      drain();
    end

    if (mismatches == 0 && chars_outstanding == 0) begin
      $display("keyword_substitution_cipher regression: pass");
    end else begin
      $display("keyword_substitution_cipher regression: fail");
    end
    $finish;
  end

endmodule
